// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked on the rising clock edge outside reset.
`define RRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// A stalled beat keeps valid high and its payload unchanged.
`define RRA_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error("%m: stalled beat changed");

`endif

// ----- design/rra_pkg.sv -----
// Shared types, constants and lookup functions of the round-robin ADC averager.
package rra_pkg;

  localparam int unsigned SampleW        = 10;
  localparam int unsigned GainW          = 16;
  localparam int unsigned ChanW          = 2;
  localparam int unsigned NumChan        = 4;
  localparam int unsigned CurW           = 16;
  localparam int unsigned MuxW           = 5;
  localparam int unsigned FracBits       = 10;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned Log2SamplesDef = 4;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][GainW-1:0] gain_bank_t;

  typedef struct packed {
    chan_t              channel;
    logic [SampleW-1:0] mean;
  } mean_beat_t;

  localparam chan_t Chan0 = 2'd0;
  localparam chan_t Chan1 = 2'd1;
  localparam chan_t Chan2 = 2'd2;
  localparam chan_t Chan3 = 2'd3;

  // Multiplexer codes that select the following channel.
  localparam logic [MuxW-1:0] MuxAfterCh0 = 5'b01101;
  localparam logic [MuxW-1:0] MuxAfterCh1 = 5'b00100;
  localparam logic [MuxW-1:0] MuxAfterCh2 = 5'b00101;
  localparam logic [MuxW-1:0] MuxAfterCh3 = 5'b01001;

  // Q6.10 gains: 3.68 for the first two channels, 0.6745 for the others.
  localparam logic [GainW-1:0] GainHigh = 16'd3768;
  localparam logic [GainW-1:0] GainLow  = 16'd691;

  function automatic logic [MuxW-1:0] mux_after(chan_t ch);
    logic [MuxW-1:0] code;
    case (ch)
      Chan0:   code = MuxAfterCh0;
      Chan1:   code = MuxAfterCh1;
      Chan2:   code = MuxAfterCh2;
      Chan3:   code = MuxAfterCh3;
      default: code = MuxAfterCh0;
    endcase
    return code;
  endfunction

  function automatic logic [GainW-1:0] gain_reset(chan_t ch);
    logic [GainW-1:0] g;
    case (ch)
      Chan0, Chan1: g = GainHigh;
      Chan2, Chan3: g = GainLow;
      default:      g = GainHigh;
    endcase
    return g;
  endfunction

endpackage

// ----- design/rra_in_if.sv -----
// Sample channel: one raw converter result per beat.
interface rra_in_if;
  logic                         valid;
  logic                         ready;
  logic [rra_pkg::SampleW-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/rra_out_if.sv -----
// Result channel: one averaged channel current per beat.
interface rra_out_if;
  logic                       valid;
  logic                       ready;
  logic [rra_pkg::ChanW-1:0]  channel;
  logic [rra_pkg::CurW-1:0]   current_ma;
  logic [rra_pkg::MuxW-1:0]   next_mux_code;

  modport source (output valid, output channel, output current_ma, output next_mux_code,
                  input ready);
  modport sink   (input valid, input channel, input current_ma, input next_mux_code,
                  output ready);
endinterface

// ----- design/rra_accum.sv -----
// Per-channel sample accumulator with round-robin channel sequencing.
module rra_accum #(
  parameter int unsigned LOG2_SAMPLES = rra_pkg::Log2SamplesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rra_in_if.sink              in_i,
  output rra_pkg::mean_beat_t beat_o,
  output logic                beat_valid_o,
  input  logic                beat_ready_i
);

  localparam int unsigned SumW = rra_pkg::SampleW + LOG2_SAMPLES;
  localparam int unsigned CntW = LOG2_SAMPLES + 1;
  localparam logic [CntW-1:0] CntReload = CntW'(2 ** LOG2_SAMPLES);

  logic [SumW-1:0]      sum_q, sum_d, sum_add;
  logic [CntW-1:0]      cnt_q, cnt_d;
  rra_pkg::chan_t       chan_q, chan_d;
  logic                 beat_vld_q, beat_vld_d;
  rra_pkg::mean_beat_t  beat_q;
  logic                 accept;
  logic                 last;

  assign in_i.ready = !beat_vld_q || beat_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign sum_add    = sum_q + SumW'(in_i.sample);
  assign last       = (cnt_q == CntW'(1));

  always_comb begin
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    chan_d     = chan_q;
    beat_vld_d = beat_vld_q && !beat_ready_i;
    if (accept) begin
      if (last) begin
        sum_d      = '0;
        cnt_d      = CntReload;
        chan_d     = chan_q + rra_pkg::chan_t'(1);
        beat_vld_d = 1'b1;
      end else begin
        sum_d = sum_add;
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      cnt_q      <= CntReload;
      chan_q     <= rra_pkg::Chan0;
      beat_vld_q <= 1'b0;
    end else begin
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      chan_q     <= chan_d;
      beat_vld_q <= beat_vld_d;
    end
  end

  // The mean is the top bits of the final sum.
  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      beat_q.channel <= chan_q;
      beat_q.mean    <= sum_add[SumW-1 -: rra_pkg::SampleW];
    end
  end

  assign beat_o       = beat_q;
  assign beat_valid_o = beat_vld_q;

endmodule

// ----- design/rra_scale.sv -----
// Gain multiply and result register for finished channel means.
module rra_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rra_pkg::mean_beat_t beat_i,
  input  logic                beat_valid_i,
  output logic                beat_ready_o,
  input  rra_pkg::gain_bank_t gains_i,
  rra_out_if.source           out_o
);

  localparam int unsigned ProdW = rra_pkg::SampleW + rra_pkg::GainW;

  logic                        out_vld_q, out_vld_d;
  logic                        take;
  logic [ProdW-1:0]            product;
  rra_pkg::chan_t              chan_q;
  logic [rra_pkg::CurW-1:0]    cur_q;
  logic [rra_pkg::MuxW-1:0]    mux_q;

  assign beat_ready_o = !out_vld_q || out_o.ready;
  assign take         = beat_valid_i && beat_ready_o;
  assign product      = ProdW'(beat_i.mean) * ProdW'(gains_i[beat_i.channel]);
  assign out_vld_d    = take || (out_vld_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Dropping the ten fraction bits truncates toward zero.
  always_ff @(posedge clk_i) begin
    if (take) begin
      chan_q <= beat_i.channel;
      cur_q  <= product[rra_pkg::FracBits +: rra_pkg::CurW];
      mux_q  <= rra_pkg::mux_after(beat_i.channel);
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.channel       = chan_q;
  assign out_o.current_ma    = cur_q;
  assign out_o.next_mux_code = mux_q;

endmodule

// ----- design/round_robin_adc_averager.sv -----
// Round-robin ADC averager: accepts one sample per cycle, no stall while output drains.
// A channel's last sample reaches the output via the accumulator's beat register, then the
// result register. Throughput: one sample per cycle while the output drains; one result
// per 2^LOG2_SAMPLES samples, set by the accumulator stage and the registered gain multiply.
// Reset: gains return to their defaults, sum clears, channel zero, full sample count,
// both pipeline stages empty.
module round_robin_adc_averager #(
  parameter int unsigned LOG2_SAMPLES = rra_pkg::Log2SamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rra_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rra_pkg::CfgDataW-1:0]  cfg_wdata_i,
  rra_in_if.sink                        in_i,
  rra_out_if.source                     out_o
);

  rra_pkg::gain_bank_t gains_q;
  rra_pkg::mean_beat_t beat;
  logic                beat_valid;
  logic                beat_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rra_pkg::NumChan; i++) begin
        gains_q[i] <= rra_pkg::gain_reset(rra_pkg::chan_t'(i));
      end
    end else if (cfg_we_i) begin
      gains_q[cfg_idx_i] <= cfg_wdata_i[rra_pkg::GainW-1:0];
    end
  end

  rra_accum #(
    .LOG2_SAMPLES(LOG2_SAMPLES)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .beat_o      (beat),
    .beat_valid_o(beat_valid),
    .beat_ready_i(beat_ready)
  );

  rra_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .beat_valid_i(beat_valid),
    .beat_ready_o(beat_ready),
    .gains_i     (gains_q),
    .out_o       (out_o)
  );

endmodule

// ----- design/rra_checker.sv -----
// Port-level checker for the round-robin ADC averager, bound to the top level.
`include "assert_macros.svh"

module rra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rra_pkg::ChanW-1:0]   out_channel_i,
  input logic [rra_pkg::CurW-1:0]    out_current_ma_i,
  input logic [rra_pkg::MuxW-1:0]    out_next_mux_code_i
);

  localparam int unsigned PayloadW = rra_pkg::ChanW + rra_pkg::CurW + rra_pkg::MuxW;

  rra_pkg::chan_t        exp_chan_q;
  logic                  in_beat;
  logic                  out_beat;
  logic [PayloadW-1:0]   out_payload;

  assign in_beat     = in_valid_i && in_ready_i;
  assign out_beat    = out_valid_i && out_ready_i;
  assign out_payload = {out_channel_i, out_current_ma_i, out_next_mux_code_i};

  // Results must visit the channels in strict rotation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_chan_q <= rra_pkg::Chan0;
    end else if (out_beat) begin
      exp_chan_q <= exp_chan_q + rra_pkg::chan_t'(1);
    end
  end

  `RRA_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_payload)
  `RRA_ASSERT(a_chan_order, clk_i, rst_ni, out_valid_i |-> (out_channel_i == exp_chan_q))
  `RRA_ASSERT(a_result_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_beat, 2))
  `RRA_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_i |-> (out_valid_i && !out_ready_i))

endmodule

bind round_robin_adc_averager rra_checker u_rra_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_channel_i      (out_o.channel),
  .out_current_ma_i   (out_o.current_ma),
  .out_next_mux_code_i(out_o.next_mux_code)
);
